// ----- hw/rtl/ptbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Portable text byte checker package
// Report kinds, field widths and the report record shared by the block.
// ----------------------------------------------------------------------------
package ptbc_pkg;

  localparam int LINE_W = 24;
  localparam int COL_W  = 16;
  localparam int BYTE_W = 8;

  typedef enum logic [2:0] {
    KIND_CRLF      = 3'd0,
    KIND_LONE_CR   = 3'd1,
    KIND_WORD_DOC  = 3'd2,
    KIND_NONPORT   = 3'd3,
    KIND_SPACE     = 3'd4,
    KIND_BULLET    = 3'd5,
    KIND_QUOTE     = 3'd6,
    KIND_COPYRIGHT = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [BYTE_W-1:0]  code;
    logic               last;
  } res_t;

  // reports raised by one accepted byte, up to two
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- hw/rtl/ptbc_step.sv -----
// ----------------------------------------------------------------------------
// Portable text byte checker step
// Per-file state and its update for one accepted byte.
// ----------------------------------------------------------------------------
module ptbc_step import ptbc_pkg::*; #(
  parameter int TAB_STOP    = 8,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              new_file_i,
  output push_t             push_o
);

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TL  = 8'h7E;
  localparam logic [7:0] CHAR_WD0 = 8'hD0;
  localparam logic [7:0] CHAR_WD1 = 8'h03;
  localparam logic [7:0] LIMIT_RST = 8'd10;

  localparam int PW  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int AW  = $clog2(TAB_STOP + 1);
  localparam int CW1 = COLUMN_BITS + 1;
  localparam int LW  = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
  localparam int CW  = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;
  localparam longint unsigned COL_MAX_L = (64'd1 << COLUMN_BITS) - 64'd1;
  localparam int COL_MAX_PH = int'(COL_MAX_L % TAB_STOP);
  localparam logic [LINE_W-1:0] LINE_FMAX = '1;
  localparam logic [COL_W-1:0]  COL_FMAX  = '1;

  function automatic kind_e classify(input logic [7:0] b);
    kind_e k;
    unique case (b)
      8'h80:                             k = KIND_SPACE;
      8'h95, 8'h98:                      k = KIND_BULLET;
      8'h91, 8'h92, 8'h93, 8'h94,
      8'hBF, 8'hC2:                      k = KIND_QUOTE;
      8'h99, 8'hA9, 8'hBD, 8'hE3, 8'hEF: k = KIND_COPYRIGHT;
      default:                           k = KIND_NONPORT;
    endcase
    return k;
  endfunction

  logic [7:0]             limit_q;
  logic [LINE_BITS-1:0]   line_q, line_d, line_e;
  logic [COLUMN_BITS-1:0] col_q, col_d, col_e;
  logic [PW-1:0]          ph_q, ph_d, ph_e;
  logic [7:0]             err_q, err_d, err_e;
  logic                   cr_q, cr_d, cr_e;
  logic                   rep_q, rep_d, rep_e;
  logic                   crlf_q, crlf_d, crlf_e;
  logic                   stop_q, stop_d, stop_e;

  logic                   ignore;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LW-1:0]          line_wide;
  logic [LINE_W-1:0]      rep_line;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [CW-1:0]          col_wide;
  logic [COL_W-1:0]       rep_col;
  logic [AW-1:0]          adv;
  logic [CW1-1:0]         col_sum;
  res_t                   res_a, res_b;
  logic [1:0]             n;

  always_comb begin
    line_e = new_file_i ? '0 : line_q;
    col_e  = new_file_i ? '0 : col_q;
    ph_e   = new_file_i ? '0 : ph_q;
    err_e  = new_file_i ? '0 : err_q;
    cr_e   = new_file_i ? 1'b0 : cr_q;
    rep_e  = new_file_i ? 1'b0 : rep_q;
    crlf_e = new_file_i ? 1'b0 : crlf_q;
    stop_e = new_file_i ? 1'b0 : stop_q;
  end

  always_comb begin
    line_inc  = (&line_e) ? line_e : line_e + LINE_BITS'(1);
    line_wide = LW'(line_inc);
    rep_line  = (line_wide > LW'(LINE_FMAX)) ? LINE_FMAX : line_wide[LINE_W-1:0];
    col_inc   = (&col_e) ? col_e : col_e + COLUMN_BITS'(1);
    col_wide  = CW'(col_inc);
    rep_col   = (col_wide > CW'(COL_FMAX)) ? COL_FMAX : col_wide[COL_W-1:0];
    adv       = AW'(TAB_STOP) - AW'(ph_e);
    col_sum   = {1'b0, col_e} + CW1'(adv);
  end

  always_comb begin
    ignore = stop_e || (err_e >= limit_q);
    line_d = line_e;
    col_d  = col_e;
    ph_d   = ph_e;
    err_d  = err_e;
    cr_d   = cr_e;
    rep_d  = rep_e;
    crlf_d = crlf_e;
    stop_d = stop_e;
    res_a  = '0;
    res_b  = '0;
    n      = 2'd0;
    if (!ignore) begin
      cr_d = (byte_i == CHAR_CR);
      if (byte_i == CHAR_LF) begin
        if (cr_e && !crlf_e) begin
          crlf_d     = 1'b1;
          res_a.kind = KIND_CRLF;
          res_a.line = rep_line;
          n          = 2'd1;
        end
        line_d = line_inc;
        col_d  = '0;
        ph_d   = '0;
        rep_d  = 1'b0;
      end else if (byte_i != CHAR_CR) begin
        if (cr_e) begin
          res_a.kind = KIND_LONE_CR;
          res_a.line = rep_line;
          res_a.col  = rep_col;
          res_a.code = CHAR_CR;
          n          = 2'd1;
          err_d      = (&err_e) ? err_e : err_e + 8'd1;
        end
        priority if (byte_i == CHAR_TAB) begin
          if (col_sum[COLUMN_BITS]) begin
            col_d = '1;
            ph_d  = PW'(COL_MAX_PH);
          end else begin
            col_d = col_sum[COLUMN_BITS-1:0];
            ph_d  = '0;
          end
        end else if (byte_i >= CHAR_SP && byte_i <= CHAR_TL) begin
          if (!(&col_e)) begin
            col_d = col_inc;
            ph_d  = (ph_e == PW'(TAB_STOP - 1)) ? '0 : ph_e + PW'(1);
          end
        end else if (!rep_e) begin
          rep_d = 1'b1;
          if ((byte_i == CHAR_WD0 && line_e == '0 && col_e == '0) ||
              (byte_i == CHAR_WD1 && line_e == '0 && col_e == COLUMN_BITS'(2))) begin
            res_b.kind = KIND_WORD_DOC;
            res_b.line = LINE_W'(1);
            stop_d     = 1'b1;
          end else begin
            res_b.kind = classify(byte_i);
            res_b.line = rep_line;
            res_b.col  = rep_col;
            res_b.code = byte_i;
            err_d      = (&err_d) ? err_d : err_d + 8'd1;
          end
          if (n == 2'd0) begin
            res_a = res_b;
            n     = 2'd1;
          end else begin
            n = 2'd2;
          end
        end else begin
          col_d = col_e;
        end
      end
    end
    if (n == 2'd1) res_a.last = 1'b1;
    if (n == 2'd2) res_b.last = 1'b1;
    push_o.n  = accept_i ? n : 2'd0;
    push_o.r0 = res_a;
    push_o.r1 = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      col_q  <= '0;
      ph_q   <= '0;
      err_q  <= '0;
      cr_q   <= 1'b0;
      rep_q  <= 1'b0;
      crlf_q <= 1'b0;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      line_q <= line_d;
      col_q  <= col_d;
      ph_q   <= ph_d;
      err_q  <= err_d;
      cr_q   <= cr_d;
      rep_q  <= rep_d;
      crlf_q <= crlf_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ----- hw/rtl/ptbc_res_fifo.sv -----
// ----------------------------------------------------------------------------
// Portable text byte checker report queue
// Four-entry queue taking up to two reports per cycle, one beat out.
// ----------------------------------------------------------------------------
module ptbc_res_fifo import ptbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= NW'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + AW'(push_i.n);
    rd_d  = rd_q + AW'(pop);
    cnt_d = cnt_q + NW'(push_i.n) - NW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + AW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("report queue overfilled");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd2) |-> (push_i.r1.last && !push_i.r0.last))
    else $error("report pair marked wrongly");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd1) |-> push_i.r0.last)
    else $error("single report not marked last");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.n == 2'd0) |=> (cnt_q == $past(cnt_q) - NW'(1)))
    else $error("queue count lost track");

endmodule

// ----- hw/rtl/portable_text_byte_checker_core.sv -----
// ----------------------------------------------------------------------------
// Portable text byte checker
// Checks a text byte stream for non-portable content and line-end faults.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Each byte is handled in the cycle it is
// accepted and raises zero, one or two reports, which wait in a four-entry
// queue and leave one beat per cycle when m_axis_tready is high, which sets
// the sustained rate: one output beat per report. A byte is accepted while
// the queue has room for two reports. Report tdata carries line, column and
// byte code; tuser carries the kind and tlast marks a byte's last report.
// The user writes error_limit only while idle; the block does not check.
module portable_text_byte_checker_core import ptbc_pkg::*; #(
  parameter int TAB_STOP    = 8,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_axis_tuser,   // [0] new_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] line, [39:24] column, [47:40] byte code
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  ptbc_step #(
    .TAB_STOP    (TAB_STOP),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .new_file_i  (s_axis_tuser[0]),
    .push_o      (push)
  );

  ptbc_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {head.code, head.col, head.line};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
